FILE: rtl/smseq_pkg.sv
package smseq_pkg;

    typedef enum logic [1:0] {
        CMD_STEP    = 2'd0,
        CMD_LOAD    = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_NOP     = 2'd3
    } command_t;

    typedef enum logic {
        REG_MICROSTEPS_PER_REV = 1'b0,
        REG_TARGET_POSITION    = 1'b1
    } reg_index_t;

    localparam int POS_W = 16;
    localparam int AMP_W = 12;
    localparam int CURVE_LAST = 16;
    localparam logic [POS_W-1:0] MICROSTEPS_PER_REV_RESET = 16'd3200;

    localparam logic [AMP_W-1:0] SINE_QUARTER [0:CURVE_LAST] = '{
        12'd0,    12'd401,  12'd799,  12'd1189, 12'd1567, 12'd1930,
        12'd2275, 12'd2598, 12'd2896, 12'd3165, 12'd3405, 12'd3611,
        12'd3783, 12'd3919, 12'd4016, 12'd4075, 12'd4095
    };

    // Coil polarity pattern per quadrant of the electrical phase.
    localparam logic [3:0] QUADRANT_PATTERN [0:3] = '{4'h3, 4'h6, 4'hC, 4'h9};

    typedef struct packed {
        logic [AMP_W-1:0] amplitude_a;
        logic [AMP_W-1:0] amplitude_b;
        logic             coil_a_in1;
        logic             coil_a_in2;
        logic             coil_b_in1;
        logic             coil_b_in2;
    } drive_t;

endpackage

FILE: rtl/smseq_drive.sv
module smseq_drive #(
    parameter int MICROSTEPS_PER_STEP = 16
) (
    input  logic [$clog2(4*MICROSTEPS_PER_STEP)-1:0] phase,
    input  logic                                     enabled,
    output smseq_pkg::drive_t                        drive
);
    import smseq_pkg::*;

    localparam int M       = MICROSTEPS_PER_STEP;
    localparam int PHASE_W = $clog2(4*M);
    localparam int IDX_W   = $clog2(M+1);
    localparam logic [PHASE_W-1:0] M1 = PHASE_W'(M);
    localparam logic [PHASE_W-1:0] M2 = PHASE_W'(2*M);
    localparam logic [PHASE_W-1:0] M3 = PHASE_W'(3*M);
    localparam logic [IDX_W-1:0]   M_IDX = IDX_W'(M);

    logic [AMP_W-1:0]   curve_lut [0:M];
    logic [1:0]         quadrant;
    logic [PHASE_W-1:0] base;
    logic [IDX_W-1:0]   offset;
    logic [IDX_W-1:0]   mirror;
    logic [AMP_W-1:0]   amp_offset;
    logic [AMP_W-1:0]   amp_mirror;
    logic [3:0]         pattern;

    // Curve entry i is the quarter-sine sample nearest to i/M of a quarter turn.
    for (genvar i = 0; i <= M; i++) begin : g_curve
        localparam int K  = (i*CURVE_LAST + M/2) / M;
        localparam int KC = (K > CURVE_LAST) ? CURVE_LAST : K;
        assign curve_lut[i] = SINE_QUARTER[KC];
    end

    always_comb begin
        if (phase >= M3) begin
            quadrant = 2'd3;
            base     = M3;
        end else if (phase >= M2) begin
            quadrant = 2'd2;
            base     = M2;
        end else if (phase >= M1) begin
            quadrant = 2'd1;
            base     = M1;
        end else begin
            quadrant = 2'd0;
            base     = '0;
        end
        offset     = IDX_W'(phase - base);
        mirror     = M_IDX - offset;
        amp_offset = curve_lut[offset];
        amp_mirror = curve_lut[mirror];
        pattern    = QUADRANT_PATTERN[quadrant];

        drive = '0;
        if (enabled) begin
            if (quadrant[0] == 1'b0) begin
                drive.amplitude_a = amp_mirror;
                drive.amplitude_b = amp_offset;
            end else begin
                drive.amplitude_a = amp_offset;
                drive.amplitude_b = amp_mirror;
            end
            drive.coil_a_in1 = pattern[2];
            drive.coil_a_in2 = pattern[0];
            drive.coil_b_in1 = pattern[1];
            drive.coil_b_in2 = pattern[3];
        end
    end

endmodule

FILE: rtl/stepper_microstep_sequencer.sv
// Bipolar stepper microstep sequencer.
// Requests arrive on the s_ stream: step one microstep (forward or backward),
// load an absolute position, or release the coils. Every request produces
// exactly one result on the m_ stream with the position, the at-target flag,
// both coil amplitudes, the four coil input levels and a range error flag for
// a rejected load.
// The state update and the sine lookup happen in the cycle a request is
// accepted, and the result appears in the output register on the next
// cycle. Throughput is one request per cycle while the receiver keeps up;
// the only storage between the two sides is that output register, so s_tready
// stays high while the register is empty or being drained in the same cycle.
// When the receiver stalls, the result is held and s_tready drops until it is
// taken. Reset clears the position, the electrical phase and the drive enable
// (coils off), sets the revolution length to 3200 and the target to 0, and
// empties the output register. Configuration writes through cfg_wr_en are
// taken in any cycle and must only be issued while the block is idle.
module stepper_microstep_sequencer #(
    parameter int MICROSTEPS_PER_STEP = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,

    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] command, [2] direction, [18:3] new_position, [23:19] zero
    input  logic [23:0] s_tdata,

    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] position, [16] at_target, [28:17] amplitude_a,
    // [40:29] amplitude_b, [41] coil_a_in1, [42] coil_a_in2,
    // [43] coil_b_in1, [44] coil_b_in2, [45] range_error, [47:46] zero
    output logic [47:0] m_tdata
);
    import smseq_pkg::*;

    localparam int PHASE_W = $clog2(4*MICROSTEPS_PER_STEP);
    localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(4*MICROSTEPS_PER_STEP - 1);

    logic [POS_W-1:0]   rev_cfg_reg;
    logic [POS_W-1:0]   target_reg;
    logic [POS_W-1:0]   position_reg, position_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic               drive_en_reg, drive_en_next;
    logic               range_err_next;

    logic               out_valid_reg;
    logic [POS_W-1:0]   out_position_reg;
    logic               out_at_target_reg;
    drive_t             out_drive_reg;
    logic               out_range_err_reg;

    logic               accept;
    command_t           command;
    logic               direction;
    logic [POS_W-1:0]   new_position;
    logic [POS_W:0]     rev_len;
    logic [POS_W:0]     pos_inc;
    drive_t             drive_next;

    assign command      = command_t'(s_tdata[1:0]);
    assign direction    = s_tdata[2];
    assign new_position = s_tdata[18:3];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // A zero revolution length wraps over the full 16 bits.
    assign rev_len = (rev_cfg_reg == '0) ? {1'b1, {POS_W{1'b0}}} : {1'b0, rev_cfg_reg};
    assign pos_inc = {1'b0, position_reg} + 1'b1;

    always_comb begin
        position_next  = position_reg;
        phase_next     = phase_reg;
        drive_en_next  = drive_en_reg;
        range_err_next = 1'b0;
        case (command)
            CMD_STEP: begin
                if (direction) begin
                    position_next = (pos_inc >= rev_len) ? '0 : pos_inc[POS_W-1:0];
                    phase_next    = (phase_reg == PHASE_LAST) ? '0 : phase_reg + 1'b1;
                end else begin
                    // Stepping back from zero, or from beyond a shrunk
                    // revolution, lands on the last position.
                    if (position_reg == '0 || {1'b0, position_reg} > rev_len) begin
                        position_next = POS_W'(rev_len - 1'b1);
                    end else begin
                        position_next = position_reg - 1'b1;
                    end
                    phase_next = (phase_reg == '0) ? PHASE_LAST : phase_reg - 1'b1;
                end
                drive_en_next = 1'b1;
            end
            CMD_LOAD: begin
                if ({1'b0, new_position} >= rev_len) begin
                    range_err_next = 1'b1;
                end else begin
                    position_next = new_position;
                end
            end
            CMD_RELEASE: begin
                drive_en_next = 1'b0;
            end
            default: begin
            end
        endcase
    end

    smseq_drive #(
        .MICROSTEPS_PER_STEP(MICROSTEPS_PER_STEP)
    ) u_drive (
        .phase  (phase_next),
        .enabled(drive_en_next),
        .drive  (drive_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rev_cfg_reg   <= MICROSTEPS_PER_REV_RESET;
            target_reg    <= '0;
            position_reg  <= '0;
            phase_reg     <= '0;
            drive_en_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (reg_index_t'(cfg_index))
                    REG_MICROSTEPS_PER_REV: rev_cfg_reg <= cfg_wdata;
                    REG_TARGET_POSITION:    target_reg  <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                position_reg  <= position_next;
                phase_reg     <= phase_next;
                drive_en_reg  <= drive_en_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_position_reg  <= position_next;
            out_at_target_reg <= (position_next == target_reg);
            out_drive_reg     <= drive_next;
            out_range_err_reg <= range_err_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {
        2'b00,
        out_range_err_reg,
        out_drive_reg.coil_b_in2,
        out_drive_reg.coil_b_in1,
        out_drive_reg.coil_a_in2,
        out_drive_reg.coil_a_in1,
        out_drive_reg.amplitude_b,
        out_drive_reg.amplitude_a,
        out_at_target_reg,
        out_position_reg
    };

endmodule
